### rtl/core/h264_rtp_fu_a_packetizer_core_assert.svh
// Assertion macros shared by the RTP FU-A packetizer RTL.
// Each module that asserts includes this file; the macros expect aclk and aresetn in scope.
`ifndef H264_RTP_FU_A_PACKETIZER_CORE_ASSERT_SVH
`define H264_RTP_FU_A_PACKETIZER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define H264FU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("packetizer assertion failed");

// Next-cycle implication, checked outside of reset.
`define H264FU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("packetizer assertion failed");

`endif

### rtl/core/h264fu_pkg.sv
// Shared types and constants for the H.264 RTP FU-A packetizer.
// Used by the front end, the job queue, the back end and the top level.
package h264fu_pkg;

    // Width of the unit size and of the byte position counter.
    localparam int SIZE_BITS = 24;

    // Configuration register indexes and reset values.
    localparam logic [1:0] CFG_PAYLOAD_TYPE   = 2'd0;
    localparam logic [1:0] CFG_SSRC           = 2'd1;
    localparam logic [1:0] CFG_MAX_PAYLOAD    = 2'd2;
    localparam logic [1:0] CFG_TS_STEP        = 2'd3;

    localparam logic [6:0]  RST_PAYLOAD_TYPE = 7'd96;
    localparam logic [31:0] RST_SSRC         = 32'd10;
    localparam logic [11:0] RST_MAX_PAYLOAD  = 12'd1400;
    localparam logic [16:0] RST_TS_STEP      = 17'd3600;

    // Fixed packet bytes.
    localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
    localparam logic [4:0] FU_A_TYPE        = 5'd28;

    // Byte slots of one job as the back end walks them.
    localparam logic [3:0] SLOT_LAST_RTP = 4'd11;
    localparam logic [3:0] SLOT_FU_IND   = 4'd12;
    localparam logic [3:0] SLOT_FU_HDR   = 4'd13;
    localparam logic [3:0] SLOT_PAYLOAD  = 4'd14;

    // Job queue geometry.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_CHECK,
        MODE_SINGLE,
        MODE_FRAG
    } mode_t;

    typedef enum logic [1:0] {
        HDR_NONE,
        HDR_SINGLE,
        HDR_FRAG
    } hdr_kind_t;

    // One payload byte plus the header it opens, if any.
    typedef struct packed {
        hdr_kind_t   kind;
        logic        marker;
        logic [15:0] seq;
        logic [31:0] ts;
        logic [7:0]  fu_ind;
        logic [7:0]  fu_hdr;
        logic [7:0]  payload;
        logic        pkt_end;
    } job_t;

endpackage

### rtl/core/h264fu_front.sv
// Front end: start code check, unit classification and job building.
// Depends on h264fu_pkg; pushes one job per input byte that causes output.
`include "h264_rtp_fu_a_packetizer_core_assert.svh"
module h264fu_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           nal_byte,
    input  logic                 unit_first,
    input  logic [23:0]          unit_size,
    input  logic [11:0]          max_payload,
    input  logic [16:0]          ts_step,
    input  logic                 q_full,
    output logic                 q_push,
    output h264fu_pkg::job_t     q_job
);
    import h264fu_pkg::*;

    logic [SIZE_BITS-1:0] pos_reg, pos_next;
    logic [2:0]           scl_reg, scl_next;
    logic [7:0]           nal_hdr_reg, nal_hdr_next;
    logic [11:0]          fc_reg, fc_next;
    mode_t                mode_reg, mode_next;
    logic [15:0]          seq_reg, seq_next;
    logic [31:0]          ts_reg, ts_next;

    logic                 accept;
    logic [SIZE_BITS-1:0] size;
    logic [SIZE_BITS-1:0] pos_e;
    logic [2:0]           scl_e;
    logic [11:0]          fc_e;
    mode_t                mode_e;
    logic [SIZE_BITS:0]   pos_inc;
    logic                 unit_end;
    logic [11:0]          mp;
    logic [SIZE_BITS-1:0] data_len;
    logic [SIZE_BITS-1:0] rem_len;
    logic                 last_frag;
    logic                 s_bit;
    logic [11:0]          fc_inc;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign size     = SIZE_BITS'(unit_size);
    assign mp       = (max_payload == 12'd0) ? 12'd1 : max_payload;

    // A new unit restarts the per-unit state before anything else is judged.
    always_comb begin
        if (unit_first) begin
            pos_e  = '0;
            scl_e  = 3'd0;
            fc_e   = 12'd0;
            mode_e = (size <= SIZE_BITS'(4)) ? MODE_IDLE : MODE_CHECK;
        end else begin
            pos_e  = pos_reg;
            scl_e  = scl_reg;
            fc_e   = fc_reg;
            mode_e = mode_reg;
        end
    end

    // Length arithmetic for the current byte.
    always_comb begin
        pos_inc   = {1'b0, pos_e} + 1'b1;
        unit_end  = pos_inc >= {1'b0, size};
        data_len  = (size > SIZE_BITS'(scl_e)) ? size - SIZE_BITS'(scl_e) : SIZE_BITS'(1);
        rem_len   = (size > pos_e) ? size - pos_e : SIZE_BITS'(1);
        last_frag = rem_len <= SIZE_BITS'(mp);
        s_bit     = pos_e == (SIZE_BITS'(scl_e) + SIZE_BITS'(1));
        fc_inc    = fc_e + 12'd1;
    end

    // Per-byte decision and job assembly.
    always_comb begin
        pos_next     = pos_reg;
        scl_next     = scl_e;
        nal_hdr_next = nal_hdr_reg;
        fc_next      = fc_e;
        mode_next    = mode_e;
        seq_next     = seq_reg;
        ts_next      = ts_reg;
        q_push       = 1'b0;
        q_job.kind    = HDR_NONE;
        q_job.marker  = 1'b0;
        q_job.seq     = seq_reg;
        q_job.ts      = ts_reg;
        q_job.fu_ind  = {nal_hdr_reg[7:5], FU_A_TYPE};
        q_job.fu_hdr  = {s_bit, last_frag, 1'b0, nal_hdr_reg[4:0]};
        q_job.payload = nal_byte;
        q_job.pkt_end = unit_end;

        if (mode_e != MODE_IDLE) begin
            pos_next = pos_inc[SIZE_BITS-1:0];
        end

        case (mode_e)
            MODE_IDLE: begin
                pos_next = pos_e;
            end
            MODE_CHECK: begin
                if (scl_e != 3'd0) begin
                    // First NAL byte: it decides single packet versus fragments.
                    nal_hdr_next = nal_byte;
                    ts_next      = ts_reg + 32'(ts_step);
                    if (data_len <= SIZE_BITS'(mp)) begin
                        q_push       = 1'b1;
                        q_job.kind   = HDR_SINGLE;
                        q_job.marker = 1'b1;
                        q_job.ts     = ts_next;
                        seq_next     = seq_reg + 16'd1;
                        mode_next    = unit_end ? MODE_IDLE : MODE_SINGLE;
                    end else begin
                        fc_next   = 12'd0;
                        mode_next = unit_end ? MODE_IDLE : MODE_FRAG;
                    end
                end else if (pos_e < SIZE_BITS'(2)) begin
                    if (nal_byte != 8'd0) begin
                        mode_next = MODE_IDLE;
                    end
                end else if (pos_e == SIZE_BITS'(2)) begin
                    if (nal_byte == 8'd1) begin
                        scl_next = 3'd3;
                    end else if (nal_byte != 8'd0) begin
                        mode_next = MODE_IDLE;
                    end
                end else begin
                    if (nal_byte == 8'd1) begin
                        scl_next = 3'd4;
                    end else begin
                        mode_next = MODE_IDLE;
                    end
                end
            end
            MODE_SINGLE: begin
                q_push = 1'b1;
                if (unit_end) begin
                    mode_next = MODE_IDLE;
                end
            end
            MODE_FRAG: begin
                q_push = 1'b1;
                if (fc_e == 12'd0) begin
                    q_job.kind   = HDR_FRAG;
                    q_job.marker = last_frag;
                    seq_next     = seq_reg + 16'd1;
                end
                q_job.pkt_end = (fc_inc >= mp) || unit_end;
                fc_next       = q_job.pkt_end ? 12'd0 : fc_inc;
                if (unit_end) begin
                    mode_next = MODE_IDLE;
                end
            end
            default: begin
                mode_next = MODE_IDLE;
            end
        endcase

        if (!accept) begin
            q_push = 1'b0;
        end
    end

    // Control state; only an accepted byte moves it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            scl_reg     <= 3'd0;
            nal_hdr_reg <= 8'd0;
            fc_reg      <= 12'd0;
            mode_reg    <= MODE_IDLE;
            seq_reg     <= 16'd0;
            ts_reg      <= 32'd0;
        end else if (accept) begin
            pos_reg     <= pos_next;
            scl_reg     <= scl_next;
            nal_hdr_reg <= nal_hdr_next;
            fc_reg      <= fc_next;
            mode_reg    <= mode_next;
            seq_reg     <= seq_next;
            ts_reg      <= ts_next;
        end
    end

    // A unit only carries payload once a full start code was seen.
    `H264FU_ASSERT_IMP(a_open_unit_has_code,
        (mode_reg == MODE_SINGLE) || (mode_reg == MODE_FRAG),
        (scl_reg == 3'd3) || (scl_reg == 3'd4))

endmodule

### rtl/core/h264fu_queue.sv
// Short job queue between the front end and the back end.
// Depends on h264fu_pkg for the job type and depth.
`include "h264_rtp_fu_a_packetizer_core_assert.svh"
module h264fu_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  h264fu_pkg::job_t     push_job,
    output logic                 full,
    input  logic                 pop,
    output h264fu_pkg::job_t     head_job,
    output logic                 empty
);
    import h264fu_pkg::*;

    job_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;

    assign full     = count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign head_job = entry_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    `H264FU_ASSERT_IMP(a_no_push_when_full, full, !push)
    `H264FU_ASSERT_IMP(a_no_pop_when_empty, empty, !pop)

endmodule

### rtl/core/h264fu_back.sv
// Back end: walks each job's header and payload slots into the output register.
// Depends on h264fu_pkg; reads payload type and SSRC from the configuration.
`include "h264_rtp_fu_a_packetizer_core_assert.svh"
module h264fu_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_empty,
    input  h264fu_pkg::job_t     q_head,
    output logic                 q_pop,
    input  logic [6:0]           payload_type,
    input  logic [31:0]          ssrc,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_byte,
    output logic                 out_start,
    output logic                 out_end,
    output logic                 out_run_end
);
    import h264fu_pkg::*;

    logic [3:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       start_reg, start_next;
    logic       end_reg, end_next;
    logic       run_end_reg, run_end_next;

    logic       load;
    logic [3:0] slot;

    assign load = !valid_reg || out_ready;

    // Map the step count to a byte slot; single packets skip the FU bytes.
    always_comb begin
        case (q_head.kind)
            HDR_NONE:   slot = SLOT_PAYLOAD;
            HDR_SINGLE: slot = (idx_reg > SLOT_LAST_RTP) ? SLOT_PAYLOAD : idx_reg;
            HDR_FRAG:   slot = idx_reg;
            default:    slot = SLOT_PAYLOAD;
        endcase
    end

    // Byte selection and output register loading.
    always_comb begin
        idx_next     = idx_reg;
        valid_next   = valid_reg;
        byte_next    = byte_reg;
        start_next   = start_reg;
        end_next     = end_reg;
        run_end_next = run_end_reg;
        q_pop        = 1'b0;

        if (load) begin
            valid_next = !q_empty;
            if (!q_empty) begin
                start_next   = slot == 4'd0;
                end_next     = (slot == SLOT_PAYLOAD) && q_head.pkt_end;
                run_end_next = slot == SLOT_PAYLOAD;
                case (slot)
                    4'd0:        byte_next = RTP_VERSION_BYTE;
                    4'd1:        byte_next = {q_head.marker, payload_type};
                    4'd2:        byte_next = q_head.seq[15:8];
                    4'd3:        byte_next = q_head.seq[7:0];
                    4'd4:        byte_next = q_head.ts[31:24];
                    4'd5:        byte_next = q_head.ts[23:16];
                    4'd6:        byte_next = q_head.ts[15:8];
                    4'd7:        byte_next = q_head.ts[7:0];
                    4'd8:        byte_next = ssrc[31:24];
                    4'd9:        byte_next = ssrc[23:16];
                    4'd10:       byte_next = ssrc[15:8];
                    SLOT_LAST_RTP: byte_next = ssrc[7:0];
                    SLOT_FU_IND: byte_next = q_head.fu_ind;
                    SLOT_FU_HDR: byte_next = q_head.fu_hdr;
                    default:     byte_next = q_head.payload;
                endcase
                if (slot == SLOT_PAYLOAD) begin
                    q_pop    = 1'b1;
                    idx_next = 4'd0;
                end else begin
                    idx_next = idx_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 4'd0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Output payload holds no reset.
    always_ff @(posedge aclk) begin
        byte_reg    <= byte_next;
        start_reg   <= start_next;
        end_reg     <= end_next;
        run_end_reg <= run_end_next;
    end

    assign out_valid   = valid_reg;
    assign out_byte    = byte_reg;
    assign out_start   = start_reg;
    assign out_end     = end_reg;
    assign out_run_end = run_end_reg;

    // A header byte is never the last result of its input byte.
    `H264FU_ASSERT_IMP(a_start_not_run_end, valid_reg && start_reg, !run_end_reg)
    // A job leaves the queue together with its payload byte.
    `H264FU_ASSERT_NXT(a_pop_loads_payload, q_pop, valid_reg && run_end_reg)

endmodule

### rtl/core/h264_rtp_fu_a_packetizer_core.sv
// Top level of the H.264 RTP FU-A packetizer: configuration registers and wiring.
// Depends on h264fu_pkg, h264fu_front, h264fu_queue and h264fu_back.
//
// Usage: Annex-B NAL bytes enter on the s_ stream, one byte per transaction,
// tdata = {unit_size, nal_byte}, tuser = unit_first. RTP packet bytes leave on
// the m_ stream, one byte per transaction; tlast marks the last byte of a packet
// and tuser carries packet_start (bit 0) and run_end (bit 1).
// The first result of an accepted byte is written into the job queue and then,
// once the back end is free, into the m_ output register; a payload byte follows
// its header bytes. Throughput: one input byte per cycle while bytes map to one
// result each and m_tready stays high. A byte that opens a packet occupies the
// back end for 13 output bytes (single NAL packet) or 15 (FU-A packet), one output
// byte per cycle while m_tready is high; a four-entry job queue lets the front end
// keep accepting during that burst, after which s_tready drops. Bytes that produce
// nothing (start code, dropped units, FU-A header byte) never enter the queue.
// Reset clears sequence number, timestamp and unit state and loads the register
// defaults. When m_tready is low the output register holds and the queue fills.
// Configuration is written through cfg_we/cfg_index/cfg_wdata while idle.
module h264_rtp_fu_a_packetizer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [7:0] nal_byte, [31:8] unit_size
    input  logic        s_tuser,   // [0] unit_first
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,
    output logic [1:0]  m_tuser,   // [0] packet_start, [1] run_end
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);
    import h264fu_pkg::*;

    logic [6:0]  payload_type_reg;
    logic [31:0] ssrc_reg;
    logic [11:0] max_payload_reg;
    logic [16:0] ts_step_reg;

    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_empty;
    job_t        push_job;
    job_t        head_job;
    logic        pkt_start;
    logic        run_end;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            payload_type_reg <= RST_PAYLOAD_TYPE;
            ssrc_reg         <= RST_SSRC;
            max_payload_reg  <= RST_MAX_PAYLOAD;
            ts_step_reg      <= RST_TS_STEP;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_PAYLOAD_TYPE: payload_type_reg <= cfg_wdata[6:0];
                CFG_SSRC:         ssrc_reg         <= cfg_wdata;
                CFG_MAX_PAYLOAD:  max_payload_reg  <= cfg_wdata[11:0];
                CFG_TS_STEP:      ts_step_reg      <= cfg_wdata[16:0];
                default:          ;
            endcase
        end
    end

    h264fu_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .nal_byte    (s_tdata[7:0]),
        .unit_first  (s_tuser),
        .unit_size   (s_tdata[31:8]),
        .max_payload (max_payload_reg),
        .ts_step     (ts_step_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_job       (push_job)
    );

    h264fu_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .head_job (head_job),
        .empty    (q_empty)
    );

    h264fu_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_empty      (q_empty),
        .q_head       (head_job),
        .q_pop        (q_pop),
        .payload_type (payload_type_reg),
        .ssrc         (ssrc_reg),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_byte     (m_tdata),
        .out_start    (pkt_start),
        .out_end      (m_tlast),
        .out_run_end  (run_end)
    );

    assign m_tuser = {run_end, pkt_start};

endmodule

### tb/testbench.sv
// Self-checking testbench for the H.264 RTP FU-A packetizer core.
// Depends on h264fu_pkg and h264_rtp_fu_a_packetizer_core; the expected packet
// bytes come from a behavioral packetizer kept in a small class below.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import h264fu_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int PRINT_LIMIT = 40;

    // One expected packet byte with its flags.
    typedef struct {
        logic [7:0] data;
        logic       pkt_start;
        logic       pkt_end;
        logic       run_end;
    } packet_byte_t;

    // Behavioral packetizer plus the queue of packet bytes it still expects.
    class rtp_packet_predictor;
        logic [6:0]           payload_type = RST_PAYLOAD_TYPE;
        logic [31:0]          ssrc         = RST_SSRC;
        logic [11:0]          max_pl       = RST_MAX_PAYLOAD;
        logic [16:0]          ts_step      = RST_TS_STEP;
        logic [15:0]          seq_num      = '0;
        logic [31:0]          stamp        = '0;
        logic [SIZE_BITS-1:0] position     = '0;
        int unsigned          code_len     = 0;
        logic [7:0]           nal_hdr      = '0;
        logic [11:0]          frag_cnt     = '0;
        mode_t                mode         = MODE_IDLE;
        packet_byte_t         expected_bytes[$];
        int                   mismatches   = 0;

        function int pending();
            return expected_bytes.size();
        endfunction

        function void set_register(logic [1:0] index, logic [31:0] value);
            case (index)
                CFG_PAYLOAD_TYPE: payload_type = value[6:0];
                CFG_SSRC:         ssrc = value;
                CFG_MAX_PAYLOAD:  max_pl = value[11:0];
                CFG_TS_STEP:      ts_step = value[16:0];
                default: ;
            endcase
        endfunction

        function void push_byte(logic [7:0] data, logic pkt_start, logic pkt_end);
            packet_byte_t e;
            e.data = data;
            e.pkt_start = pkt_start;
            e.pkt_end = pkt_end;
            e.run_end = 1'b0;
            expected_bytes.push_back(e);
        endfunction

        // Fixed 12-byte RTP header; every header consumes one sequence number.
        function void push_rtp_header(logic marker);
            push_byte(RTP_VERSION_BYTE, 1'b1, 1'b0);
            push_byte({marker, payload_type}, 1'b0, 1'b0);
            push_byte(seq_num[15:8], 1'b0, 1'b0);
            push_byte(seq_num[7:0], 1'b0, 1'b0);
            push_byte(stamp[31:24], 1'b0, 1'b0);
            push_byte(stamp[23:16], 1'b0, 1'b0);
            push_byte(stamp[15:8], 1'b0, 1'b0);
            push_byte(stamp[7:0], 1'b0, 1'b0);
            push_byte(ssrc[31:24], 1'b0, 1'b0);
            push_byte(ssrc[23:16], 1'b0, 1'b0);
            push_byte(ssrc[15:8], 1'b0, 1'b0);
            push_byte(ssrc[7:0], 1'b0, 1'b0);
            seq_num = seq_num + 16'd1;
        endfunction

        // Works out the packet bytes that one accepted NAL byte causes.
        function void note_nal_byte(logic [7:0] b, logic first, logic [SIZE_BITS-1:0] size);
            int unsigned  sz, pos, mp, data_len, rem;
            logic         unit_end, last, s_bit, pend;
            int           n_before;
            packet_byte_t tail;
            sz = size;
            mp = (max_pl == 0) ? 1 : max_pl;
            n_before = expected_bytes.size();
            if (first) begin
                position = '0;
                code_len = 0;
                frag_cnt = '0;
                mode = (sz <= 4) ? MODE_IDLE : MODE_CHECK;
            end
            if (mode == MODE_IDLE)
                return;
            pos = position;
            unit_end = (pos + 1 >= sz);

            case (mode)
                MODE_CHECK: begin
                    if (code_len != 0) begin
                        // NAL header byte: pick single packet or FU-A split.
                        data_len = (sz > code_len) ? sz - code_len : 1;
                        nal_hdr = b;
                        stamp = stamp + ts_step;
                        if (data_len <= mp) begin
                            push_rtp_header(1'b1);
                            push_byte(b, 1'b0, unit_end);
                            mode = unit_end ? MODE_IDLE : MODE_SINGLE;
                        end else begin
                            frag_cnt = '0;
                            mode = unit_end ? MODE_IDLE : MODE_FRAG;
                        end
                    end else if (pos < 2) begin
                        if (b != 8'h00) mode = MODE_IDLE;
                    end else if (pos == 2) begin
                        if (b == 8'h01) code_len = 3;
                        else if (b != 8'h00) mode = MODE_IDLE;
                    end else begin
                        if (b == 8'h01) code_len = 4;
                        else mode = MODE_IDLE;
                    end
                end
                MODE_SINGLE: begin
                    push_byte(b, 1'b0, unit_end);
                    if (unit_end) mode = MODE_IDLE;
                end
                default: begin
                    // Each fragment opens with RTP header, FU indicator and FU header.
                    if (frag_cnt == 0) begin
                        rem = (sz > pos) ? sz - pos : 1;
                        last = (rem <= mp);
                        s_bit = (pos == code_len + 1);
                        push_rtp_header(last);
                        push_byte({nal_hdr[7:5], FU_A_TYPE}, 1'b0, 1'b0);
                        push_byte({s_bit, last, 1'b0, nal_hdr[4:0]}, 1'b0, 1'b0);
                    end
                    frag_cnt = frag_cnt + 12'd1;
                    pend = (frag_cnt >= mp) || unit_end;
                    push_byte(b, 1'b0, pend);
                    if (pend) frag_cnt = '0;
                    if (unit_end) mode = MODE_IDLE;
                end
            endcase

            position = SIZE_BITS'(pos + 1);
            if (expected_bytes.size() > n_before) begin
                tail = expected_bytes.pop_back();
                tail.run_end = 1'b1;
                expected_bytes.push_back(tail);
            end
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
                $display("%0t: mismatch: %s", $time, what);
        endtask

        // Compares one output transaction with the oldest expected byte.
        task check_packet_byte(logic [7:0] b, logic pkt_start, logic pkt_end, logic run_end);
            packet_byte_t e;
            if (expected_bytes.size() == 0) begin
                report($sformatf("unexpected byte %02h start %b end %b run_end %b",
                                 b, pkt_start, pkt_end, run_end));
                return;
            end
            e = expected_bytes.pop_front();
            if (b !== e.data || pkt_start !== e.pkt_start || pkt_end !== e.pkt_end ||
                run_end !== e.run_end)
                report($sformatf("got %02h/%b/%b/%b, want %02h/%b/%b/%b (byte/start/end/run_end)",
                                 b, pkt_start, pkt_end, run_end,
                                 e.data, e.pkt_start, e.pkt_end, e.run_end));
        endtask
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;   // [7:0] nal_byte, [31:8] unit_size
    logic        s_tuser   = 1'b0; // [0] unit_first
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;          // [7:0] out_byte
    logic        m_tlast;
    logic [1:0]  m_tuser;          // [0] packet_start, [1] run_end
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_wdata = '0;

    rtp_packet_predictor packets = new();

    int send_idle_pct   = 18;
    int recv_idle_pct   = 78;
    int cur_max_payload = RST_MAX_PAYLOAD;
    int stall_cycles    = 0;

    h264_rtp_fu_a_packetizer_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Receiver back-pressure, changed on the falling edge.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Transaction monitor and watchdog.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                packets.note_nal_byte(s_tdata[7:0], s_tuser, s_tdata[31:8]);
            if (m_tvalid && m_tready)
                packets.check_packet_byte(m_tdata, m_tuser[0], m_tlast, m_tuser[1]);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Presents one NAL byte and holds it until the block takes it.
    task automatic send_byte(input logic [7:0] b, input logic first,
                             input logic [SIZE_BITS-1:0] size);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {size, b};
        s_tuser  <= first;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Sends the first sent bytes of a unit. bad_at spoils one start code byte,
    // resize_at gives one byte a randomly drawn unit_size (-1 disables either).
    task automatic send_unit(input int total, input bit long_code, input int sent,
                             input int bad_at, input int resize_at);
        int         i, code;
        logic [7:0] b;
        int         size;
        code = long_code ? 4 : 3;
        for (i = 0; i < sent; i++) begin
            if (i < code)
                b = (i == code - 1) ? 8'h01 : 8'h00;
            else
                b = 8'($urandom);
            if (i == bad_at)
                b = (i < 2) ? 8'($urandom_range(1, 255)) : 8'($urandom_range(2, 255));
            size = (i == resize_at) ? $urandom_range(i + 1, total + 8) : total;
            send_byte(b, i == 0, SIZE_BITS'(size));
        end
    endtask

    // Stops sending and waits until every expected packet byte has arrived.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (packets.pending() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        packets.set_register(index, value);
        @(negedge aclk);
    endtask

    task automatic load_config(input logic [6:0] pt, input logic [31:0] ssrc,
                               input logic [11:0] mp, input logic [16:0] step);
        write_reg(CFG_PAYLOAD_TYPE, 32'(pt));
        write_reg(CFG_SSRC, ssrc);
        write_reg(CFG_MAX_PAYLOAD, 32'(mp));
        write_reg(CFG_TS_STEP, 32'(step));
        cfg_we <= 1'b0;
        cur_max_payload = int'(mp);
    endtask

    // One random unit: mostly well-formed, the rest aborted, broken or noise.
    // useful returns the bytes that belong to units the block works on.
    task automatic random_unit(output int useful);
        int kind, mp_eff, cap, nal_len, total, t, sent, code, n, i;
        bit long_code;
        useful = 0;
        kind = $urandom_range(99);
        long_code = 1'($urandom_range(1));
        code = long_code ? 4 : 3;
        mp_eff = (cur_max_payload == 0) ? 1 : cur_max_payload;
        cap = (3 * mp_eff + 2 < 60) ? 3 * mp_eff + 2 : 60;
        // Sizes around the single/fragment boundary get extra weight.
        if ($urandom_range(3) == 0 && mp_eff + 1 <= cap)
            nal_len = mp_eff + $urandom_range(1);
        else
            nal_len = $urandom_range(1, cap);
        total = code + nal_len;

        if (kind < 70) begin
            send_unit(total, long_code, total, -1,
                      ($urandom_range(9) == 0) ? $urandom_range(1, total - 1) : -1);
            useful = total;
        end else if (kind < 80) begin
            // Cut short by the next unit, sometimes with a huge unit_size.
            t = $urandom_range(1) ? $urandom_range(5, 24'hFFFFFF) : total;
            n = (t - 1 < 30) ? t - 1 : 30;
            sent = $urandom_range(1, n);
            send_unit(t, long_code, sent, -1, -1);
            useful = sent;
        end else if (kind < 88) begin
            i = $urandom_range(0, code - 1);
            send_unit(total, long_code, $urandom_range(i + 1, total), i, -1);
        end else if (kind < 94) begin
            t = $urandom_range(0, 4);
            send_unit(t, long_code, (t == 0) ? 1 : t, -1, -1);
        end else begin
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++)
                send_byte(8'($urandom), 1'b0, SIZE_BITS'($urandom));
        end
    endtask

    initial begin
        int phase, counted, useful, n;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed units under the reset register values.
        send_unit(6, 1'b1, 6, -1, -1);           // single packet after a 4-byte start code
        send_unit(4, 1'b0, 4, -1, -1);           // unit too short, dropped
        send_unit(5, 1'b0, 2, 0, -1);            // bad start code, dropped
        send_byte(8'hFF, 1'b0, 24'hFFFFFF);      // byte with no open unit
        settle();

        // Tiny fragments: an aborted FU-A unit, then a NAL one byte over the limit.
        load_config(RST_PAYLOAD_TYPE, RST_SSRC, 12'd4, RST_TS_STEP);
        send_unit(24'hFFFFFF, 1'b0, 5, -1, -1);
        send_unit(8, 1'b0, 8, -1, -1);

        for (phase = 0; phase < 6; phase++) begin
            settle();
            case (phase)
                0: load_config(7'd0, 32'd0, 12'd16, 17'd0);
                1: load_config(7'd127, 32'hFFFFFFFF, 12'd0, 17'd90000);
                2: load_config(7'($urandom_range(127)), $urandom,
                               12'($urandom_range(1, 15)), 17'($urandom_range(90000)));
                3: load_config(7'($urandom_range(127)), $urandom, 12'd4095,
                               17'($urandom_range(90000)));
                4: load_config(7'($urandom_range(127)), $urandom,
                               12'($urandom_range(16, 48)), 17'($urandom_range(90000)));
                default: load_config(7'($urandom_range(127)), $urandom,
                                     12'($urandom_range(17, 30)),
                                     17'($urandom_range(90000)));
            endcase
            send_idle_pct = (phase < 2) ? 18 : (phase < 4) ? 78 : 0;
            recv_idle_pct = (phase < 2) ? 78 : (phase < 4) ? 18 : 0;
            counted = 0;
            while (counted < 50) begin
                random_unit(useful);
                counted += useful;
            end
            // A complete unit closes the phase so no unit stays open.
            n = 3 + $urandom_range(1, 8);
            send_unit(n, 1'b0, n, -1, -1);
        end

        settle();
        repeat (20) @(negedge aclk);
        if (packets.mismatches == 0 && packets.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
